>>> sv/esr_pkg.sv
// Shared constants, status codes and types for the event subscription router.
`timescale 1ns / 1ps
`default_nettype none
package esr_pkg;

    localparam int NUM_SLOTS     = 8;
    localparam int MAP_WORDS     = 8;
    localparam int BITS_PER_WORD = 32;
    localparam int BIT_W         = 5;
    localparam int SLOT_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WORD_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int DEPTH         = NUM_SLOTS * MAP_WORDS;
    localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NUM_LIMIT     = MAP_WORDS * BITS_PER_WORD;

    localparam logic [1:0] OP_SUBSCRIBE = 2'd0;
    localparam logic [1:0] OP_PUBLISH   = 2'd1;
    localparam logic [1:0] OP_COUNT     = 2'd2;
    localparam logic [1:0] OP_NONE      = 2'd3;

    localparam logic [2:0] ST_SUBSCRIBED = 3'd0;
    localparam logic [2:0] ST_DELIVERY   = 3'd1;
    localparam logic [2:0] ST_COUNT      = 3'd2;
    localparam logic [2:0] ST_BAD_EVENT  = 3'd3;
    localparam logic [2:0] ST_NULL_TASK  = 3'd4;
    localparam logic [2:0] ST_TABLE_FULL = 3'd5;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  dest_task;
        logic [15:0] event_out;
        logic [3:0]  subscriber_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic [BITS_PER_WORD-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } t_mem_req;

endpackage
`default_nettype wire

>>> sv/esr_bitmap_mem.sv
// Subscription bitmap memory, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module esr_bitmap_mem
    import esr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_mem_req                 i_req,
    output logic [BITS_PER_WORD-1:0]      o_rdata
);

    logic [BITS_PER_WORD-1:0] r_mem [DEPTH];
    logic [BITS_PER_WORD-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> sv/esr_out_reg.sv
// Output register stage between the sequencer and the result channel.
`timescale 1ns / 1ps
`default_nettype none
module esr_out_reg
    import esr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push_valid,
    input  wire t_result i_push_data,
    output logic         o_push_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_data;

    assign o_push_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_push_ready) begin
            r_valid <= i_push_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push_ready && i_push_valid) begin
            r_data <= i_push_data;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_data;

endmodule
`default_nettype wire

>>> sv/esr_ctrl.sv
// Sequencer: clearing pass, slot search, bitmap update, scan and delivery walk.
`timescale 1ns / 1ps
`default_nettype none
module esr_ctrl
    import esr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [1:0]               i_operation,
    input  wire logic [7:0]               i_task_id,
    input  wire logic [15:0]              i_event_id,
    input  wire logic [15:0]              i_event_base,
    output t_mem_req                      o_mem_req,
    input  wire logic [BITS_PER_WORD-1:0] i_rdata,
    output logic                          o_push_valid,
    output t_result                       o_push_data,
    input  wire logic                     i_push_ready
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RESP  = 3'd2;
    localparam logic [2:0] S_FIND  = 3'd3;
    localparam logic [2:0] S_RMW   = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_DELIV = 3'd6;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [2:0]           r_state, n_state;
    logic [ADDR_W-1:0]    r_clr, n_clr;
    logic [1:0]           r_op, n_op;
    logic [7:0]           r_task, n_task;
    logic [15:0]          r_ev, n_ev;
    logic [15:0]          r_num, n_num;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [SLOT_W-1:0]    r_chk_slot, n_chk_slot;
    logic                 r_chk_valid, n_chk_valid;
    logic                 r_issue, n_issue;
    logic [NUM_SLOTS-1:0] r_mask, n_mask;
    logic [3:0]           r_count, n_count;
    t_result              r_res, n_res;
    logic [7:0]           r_slot_task [NUM_SLOTS];

    logic [15:0]          w_num;
    logic [ADDR_W-1:0]    w_addr;
    logic [NUM_SLOTS-1:0] w_sel;
    logic [NUM_SLOTS-1:0] w_rest;
    logic                 w_hit;
    t_result              w_deliv;

    assign w_num  = i_event_id - i_event_base;
    assign w_addr = ADDR_W'(r_slot) * ADDR_W'(MAP_WORDS) + ADDR_W'(r_num[BIT_W +: WORD_W]);
    assign w_sel  = NUM_SLOTS'(1) << r_slot;
    assign w_rest = r_mask & ~w_sel;
    assign w_hit  = r_chk_valid && (r_slot_task[r_chk_slot] != 8'd0)
                    && i_rdata[r_num[BIT_W-1:0]];

    always_comb begin
        w_deliv.status           = ST_DELIVERY;
        w_deliv.dest_task        = r_slot_task[r_slot];
        w_deliv.event_out        = r_ev;
        w_deliv.subscriber_count = 4'd0;
        w_deliv.last             = (w_rest == '0);
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_task      = r_task;
        n_ev        = r_ev;
        n_num       = r_num;
        n_slot      = r_slot;
        n_chk_slot  = r_chk_slot;
        n_chk_valid = r_chk_valid;
        n_issue     = r_issue;
        n_mask      = r_mask;
        n_count     = r_count;
        n_res       = r_res;
        o_ready     = 1'b0;
        o_push_valid = 1'b0;
        o_push_data = (r_state == S_DELIV) ? w_deliv : r_res;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = w_addr;
        o_mem_req.wdata = i_rdata | (BITS_PER_WORD'(1) << r_num[BIT_W-1:0]);
        o_mem_req.raddr = w_addr;

        unique case (r_state)
            S_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_clr;
                o_mem_req.wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op        = i_operation;
                    n_task      = i_task_id;
                    n_ev        = i_event_id;
                    n_num       = w_num;
                    n_slot      = '0;
                    n_mask      = '0;
                    n_count     = 4'd0;
                    n_issue     = 1'b1;
                    n_chk_valid = 1'b0;
                    n_res.dest_task        = 8'd0;
                    n_res.event_out        = i_event_id;
                    n_res.subscriber_count = 4'd0;
                    n_res.last             = 1'b1;
                    n_res.status           = ST_BAD_EVENT;
                    if (i_operation == OP_NONE) begin
                        n_state = S_IDLE;
                    end else if (w_num >= 16'(NUM_LIMIT)) begin
                        n_state = S_RESP;
                    end else if (i_operation == OP_SUBSCRIBE) begin
                        if (i_task_id == 8'd0) begin
                            n_res.status = ST_NULL_TASK;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_FIND;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_RESP: begin
                o_push_valid = 1'b1;
                if (i_push_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_FIND: begin
                if (r_slot_task[r_slot] == r_task || r_slot_task[r_slot] == 8'd0) begin
                    n_state = S_RMW;
                end else if (r_slot == LAST_SLOT) begin
                    n_res.status = ST_TABLE_FULL;
                    n_state      = S_RESP;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_RMW: begin
                o_mem_req.we = 1'b1;
                n_res.status = ST_SUBSCRIBED;
                n_state      = S_RESP;
            end
            S_SCAN: begin
                n_chk_valid = r_issue;
                n_chk_slot  = r_slot;
                if (r_issue) begin
                    if (r_slot == LAST_SLOT) begin
                        n_issue = 1'b0;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
                if (w_hit) begin
                    n_mask[r_chk_slot] = 1'b1;
                    if (r_count != 4'hF) begin
                        n_count = r_count + 1'b1;
                    end
                end
                if (r_chk_valid && r_chk_slot == LAST_SLOT) begin
                    n_slot = '0;
                    if (r_op == OP_COUNT) begin
                        n_res.status           = ST_COUNT;
                        n_res.subscriber_count = n_count;
                        n_state                = S_RESP;
                    end else if (n_mask == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_DELIV;
                    end
                end
            end
            S_DELIV: begin
                if (r_mask[r_slot]) begin
                    o_push_valid = 1'b1;
                    if (i_push_ready) begin
                        n_mask = w_rest;
                        if (w_rest == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_slot = r_slot + 1'b1;
                        end
                    end
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_slot      <= '0;
            r_chk_valid <= 1'b0;
            r_issue     <= 1'b0;
            r_mask      <= '0;
            r_count     <= 4'd0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot_task[i] <= 8'd0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_slot      <= n_slot;
            r_chk_valid <= n_chk_valid;
            r_issue     <= n_issue;
            r_mask      <= n_mask;
            r_count     <= n_count;
            if (r_state == S_RMW) begin
                r_slot_task[r_slot] <= r_task;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_task     <= n_task;
        r_ev       <= n_ev;
        r_num      <= n_num;
        r_chk_slot <= n_chk_slot;
        r_res      <= n_res;
    end

    a_push_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push_valid |-> (r_state == S_RESP || r_state == S_DELIV))
        else $error("result pushed outside a response state");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |-> (r_state == S_CLEAR || r_state == S_RMW))
        else $error("bitmap written outside clear or update");

    a_deliv_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DELIV) |-> (r_mask != '0))
        else $error("delivery walk with no pending subscribers");

    a_rmw_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |->
            (r_slot_task[r_slot] == r_task || r_slot_task[r_slot] == 8'd0))
        else $error("bitmap update on a slot owned by another task");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> (r_state != S_CLEAR && !$stable(r_ev) || r_ev == $past(i_event_id)))
        else $error("request not captured");

endmodule
`default_nettype wire

>>> sv/event_subscription_router.sv
// Top level of the event subscription router.
`timescale 1ns / 1ps
`default_nettype none
// Publish/subscribe table of NUM_SLOTS task slots, each with a bitmap of
// MAP_WORDS*32 internal event numbers (external id minus event_base, mod
// 65536). One request is worked at a time by a sequencer around a single
// bitmap memory, one slot per cycle while no delivery waits on the result
// channel. After reset the block zeroes every bitmap word before it takes a
// request; configuration writes are taken at any time. Rejected requests
// (bad event, null task) give only a response. Subscribe searches the slots
// for one owned by the task or free and sets its bit, or reports a full
// table. Count scans every slot; publish scans every slot and then walks
// the slots up to the last subscriber, each delivery waiting on the result
// channel as needed. A publish with no subscribers gives no result.
module event_subscription_router
    import esr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_task_id,
    input  wire logic [15:0] i_event_id,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [7:0]       o_dest_task,
    output logic [15:0]      o_event_out,
    output logic [3:0]       o_subscriber_count,
    output logic             o_last
);

    logic [15:0]              r_event_base;
    t_mem_req                 w_mem_req;
    logic [BITS_PER_WORD-1:0] w_rdata;
    logic                     w_push_valid;
    logic                     w_push_ready;
    t_result                  w_push_data;
    t_result                  w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_base <= 16'd0;
        end else if (i_cfg_valid) begin
            r_event_base <= i_cfg_data;
        end
    end

    esr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_task_id    (i_task_id),
        .i_event_id   (i_event_id),
        .i_event_base (r_event_base),
        .o_mem_req    (w_mem_req),
        .i_rdata      (w_rdata),
        .o_push_valid (w_push_valid),
        .o_push_data  (w_push_data),
        .i_push_ready (w_push_ready)
    );

    esr_bitmap_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    esr_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_data  (w_push_data),
        .o_push_ready (w_push_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (w_result)
    );

    assign o_status           = w_result.status;
    assign o_dest_task        = w_result.dest_task;
    assign o_event_out        = w_result.event_out;
    assign o_subscriber_count = w_result.subscriber_count;
    assign o_last             = w_result.last;

endmodule
`default_nettype wire
